// File: src/integer_field_formatter_defines.svh
// Assertion macros used by the integer field formatter's sequencer (iff_emit).
// Depends on nothing; included by iff_emit, the module that asserts.
`ifndef INTEGER_FIELD_FORMATTER_DEFINES_SVH
`define INTEGER_FIELD_FORMATTER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define IFF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define IFF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/iff_pkg.sv
// Shared types and constants of the integer field formatter.
// Depends on nothing.
package iff_pkg;

  localparam int unsigned ValW   = 32;
  localparam int unsigned DigMax = 10;  // decimal digits of a 32-bit magnitude
  localparam int unsigned NdW    = 4;

  typedef enum logic [0:0] {
    REQ_DEC = 1'b0,
    REQ_HEX = 1'b1
  } req_e;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;

  // Packed digit string, most significant digit at the highest index.
  typedef logic [DigMax-1:0][3:0] digits_t;

  // ASCII code of one digit in base 10 or 16.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) c = ChZero + {4'd0, d};
    else           c = 8'h57 + {4'd0, d};
    return c;
  endfunction

endpackage

// File: src/iff_conv.sv
// Conversion pipeline: turns a value into digits, then works out the lengths.
// Depends on iff_pkg.
module iff_conv
  import iff_pkg::*;
#(
  parameter int unsigned FieldMax = 63,
  parameter int unsigned LenW     = 6,
  parameter int unsigned TotW     = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            req_type_i,
  input  logic [ValW-1:0] value_i,
  input  logic [LenW-1:0] field_width_i,
  input  logic [LenW-1:0] min_digits_i,
  output logic            job_valid_o,
  input  logic            job_stall_i,
  output logic            job_neg_o,
  output logic [NdW-1:0]  job_nd_o,
  output logic [TotW-1:0] job_spaces_o,
  output logic [TotW-1:0] job_zeros_o,
  output logic [TotW-1:0] job_total_o,
  output digits_t         job_digs_o
);

  // 0 sign, 1..DigMax one digit each, DigMax + 1 lengths
  localparam int unsigned Stages = DigMax + 2;

  // Division by ten as a multiplication by the rounded-up reciprocal.
  localparam logic [ValW-1:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int unsigned     RecipShift = 35;

  // Stage registers; the whole pipe advances together when not stalled.
  logic [Stages-1:0] vld_q;
  logic              adv;
  assign adv        = !(vld_q[Stages-1] && job_stall_i);
  assign in_stall_o = !adv;

  logic            hex_q   [Stages-1];
  logic            neg_q   [Stages];
  logic [LenW-1:0] fw_q    [Stages-1];
  logic [LenW-1:0] pr_q    [Stages-1];
  logic [ValW-1:0] mag_q   [Stages-1];
  digits_t         digs_q  [Stages];
  logic [NdW-1:0]  nd_q;
  logic [TotW-1:0] sp_q, zr_q, tot_q;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Stages-2:0], in_valid_i};
    end
  end

  // Stage 0: sign and magnitude, widths clamped to FieldMax.
  logic            neg0;
  logic [LenW-1:0] fw0, pr0;
  always_comb begin
    neg0 = (req_type_i == REQ_DEC) && value_i[ValW-1];
    fw0  = (int'(field_width_i) > FieldMax) ? LenW'(FieldMax) : field_width_i;
    pr0  = (int'(min_digits_i)  > FieldMax) ? LenW'(FieldMax) : min_digits_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hex_q[0]  <= req_type_i;
      neg_q[0]  <= neg0;
      fw_q[0]   <= fw0;
      pr_q[0]   <= pr0;
      mag_q[0]  <= neg0 ? (ValW'(0) - value_i) : value_i;
      digs_q[0] <= '0;
    end
  end

  // Stages 1 to DigMax: one digit each, split off the low end of the magnitude.
  for (genvar s = 1; s <= DigMax; s++) begin : g_split
    logic [2*ValW-1:0] prod;
    logic [ValW-1:0]   quo, rem, mag_n;
    digits_t           digs_n;

    always_comb begin
      prod   = (2*ValW)'(mag_q[s-1]) * (2*ValW)'(RecipTen);
      quo    = ValW'(prod[2*ValW-1:RecipShift]);
      rem    = mag_q[s-1] - (quo << 3) - (quo << 1);
      digs_n = digs_q[s-1];
      if (hex_q[s-1]) begin
        digs_n[s-1] = mag_q[s-1][3:0];
        mag_n       = mag_q[s-1] >> 4;
      end else begin
        digs_n[s-1] = rem[3:0];
        mag_n       = quo;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        mag_q[s]  <= mag_n;
        digs_q[s] <= digs_n;
        hex_q[s]  <= hex_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        fw_q[s]   <= fw_q[s-1];
        pr_q[s]   <= pr_q[s-1];
      end
    end
  end

  // Last stage: digit count, zero padding, space padding, total.
  logic [NdW-1:0]  nd3;
  logic [TotW-1:0] zr3, body3, sp3;
  always_comb begin
    nd3 = NdW'(1);
    for (int k = 1; k < DigMax; k++) begin
      if (digs_q[DigMax][k] != 4'd0) nd3 = NdW'(k + 1);
    end
    if (hex_q[DigMax] && nd3 > NdW'(8)) nd3 = NdW'(8);
    zr3   = (TotW'(pr_q[DigMax]) > TotW'(nd3)) ? TotW'(pr_q[DigMax]) - TotW'(nd3) : '0;
    body3 = zr3 + TotW'(nd3) + TotW'(neg_q[DigMax]);
    sp3   = (TotW'(fw_q[DigMax]) > body3) ? TotW'(fw_q[DigMax]) - body3 : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg_q[Stages-1]  <= neg_q[DigMax];
      digs_q[Stages-1] <= digs_q[DigMax];
      nd_q             <= nd3;
      zr_q             <= zr3;
      sp_q             <= sp3;
      tot_q            <= sp3 + body3;
    end
  end

  assign job_valid_o  = vld_q[Stages-1];
  assign job_neg_o    = neg_q[Stages-1];
  assign job_nd_o     = nd_q;
  assign job_spaces_o = sp_q;
  assign job_zeros_o  = zr_q;
  assign job_total_o  = tot_q;
  assign job_digs_o   = digs_q[Stages-1];

  // The magnitude left after the last digit is always zero.
  logic unused;
  assign unused = ^mag_q[DigMax];

endmodule

// File: src/iff_emit.sv
// Character sequencer: sends one character of the current item per cycle while the receiver does not stall.
// Depends on iff_pkg and the assertion macros header.
`include "integer_field_formatter_defines.svh"
module iff_emit
  import iff_pkg::*;
#(
  parameter int unsigned TotW = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_stall_o,
  input  logic            job_neg_i,
  input  logic [NdW-1:0]  job_nd_i,
  input  logic [TotW-1:0] job_spaces_i,
  input  logic [TotW-1:0] job_zeros_i,
  input  logic [TotW-1:0] job_total_i,
  input  digits_t         job_digs_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      ch_o,
  output logic            last_o,
  output logic [TotW-1:0] char_count_o
);

  // Position within the current item; the job is held upstream until done.
  logic [TotW-1:0] pos_q, pos_d;
  logic            out_vld_q;
  logic [7:0]      ch_q;
  logic            last_q;
  logic [TotW-1:0] cnt_q;
  logic            load;
  logic [7:0]      ch_n;
  logic            last_n;
  logic [TotW-1:0] pre, didx;
  logic [NdW-1:0]  dsel;

  assign load        = job_valid_i && (!out_vld_q || !out_stall_i);
  assign job_stall_o = !(load && last_n);

  // Character at the current position.
  always_comb begin
    pre    = job_spaces_i + TotW'(job_neg_i);
    didx   = job_total_i - pos_q - TotW'(1);
    dsel   = NdW'(didx);
    last_n = (pos_q == job_total_i - TotW'(1));
    if (pos_q < job_spaces_i)                 ch_n = ChSpace;
    else if (pos_q < pre)                     ch_n = ChMinus;
    else if (pos_q < pre + job_zeros_i)       ch_n = ChZero;
    else if (dsel < job_nd_i)                 ch_n = digit_char(job_digs_i[dsel]);
    else                                      ch_n = ChZero;
    pos_d = last_n ? '0 : pos_q + TotW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (load) begin
        pos_q     <= pos_d;
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      ch_q   <= ch_n;
      last_q <= last_n;
      cnt_q  <= last_n ? job_total_i : '0;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign ch_o         = ch_q;
  assign last_o       = last_q;
  assign char_count_o = cnt_q;

  `IFF_ASSERT_IMP(a_cnt_only_last, out_vld_q && !last_q, cnt_q == '0, "count off last")
  `IFF_ASSERT_IMP(a_pos_in_range, job_valid_i, pos_q < job_total_i, "position overrun")
  `IFF_ASSERT_NEXT(a_hold_stalled, out_vld_q && out_stall_i, out_vld_q && $stable(ch_q),
                   "stalled character changed")

endmodule

// File: src/integer_field_formatter.sv
// Integer field formatter top level: a conversion pipeline feeding a sequencer.
// Depends on iff_pkg, iff_conv and iff_emit.
//
// Usage: an item (req_type, value, field_width, min_digits) enters on the
// input channel when in_valid_i is high and in_stall_o is low. The block sends
// the formatted text one ASCII character per cycle on the output channel: spaces,
// an optional minus sign, zero padding, then the digits. The final character has
// last_o set and carries the total count in char_count_o.
// The item passes twelve conversion stages (sign, one per decimal digit,
// lengths) and then one output register before its first character. Characters
// go out one per cycle while the receiver does not stall; an item has 1 to
// FIELD_MAX + 1 characters. While an item is being sent the conversion
// pipeline holds and in_stall_o stays high; the next item moves up on the
// cycle its last character is loaded, so characters of items that follow each
// other come with no gap.
// Reset clears all valid bits and the character position. When the receiver
// stalls, the output character holds, and in_stall_o is high while the last stage is full.
module integer_field_formatter
  import iff_pkg::*;
#(
  parameter int unsigned FIELD_MAX = 63
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic [ValW-1:0]              value_i,
  input  logic [5:0]                   field_width_i,
  input  logic [5:0]                   min_digits_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   ch_o,
  output logic                         last_o,
  output logic [$clog2(FIELD_MAX+2)-1:0] char_count_o
);

  localparam int unsigned TotW = $clog2(FIELD_MAX + 2);

  logic            job_valid, job_stall, job_neg;
  logic [NdW-1:0]  job_nd;
  logic [TotW-1:0] job_spaces, job_zeros, job_total;
  digits_t         job_digs;

  // Conversion pipeline.
  iff_conv #(.FieldMax(FIELD_MAX), .LenW(6), .TotW(TotW)) u_conv (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .value_i,
    .field_width_i, .min_digits_i,
    .job_valid_o(job_valid), .job_stall_i(job_stall), .job_neg_o(job_neg),
    .job_nd_o(job_nd), .job_spaces_o(job_spaces), .job_zeros_o(job_zeros),
    .job_total_o(job_total), .job_digs_o(job_digs)
  );

  // Character sequencer.
  iff_emit #(.TotW(TotW)) u_emit (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_stall_o(job_stall),
    .job_neg_i(job_neg), .job_nd_i(job_nd), .job_spaces_i(job_spaces),
    .job_zeros_i(job_zeros), .job_total_i(job_total), .job_digs_i(job_digs),
    .out_valid_o, .out_stall_i, .ch_o, .last_o, .char_count_o
  );

endmodule
